FILE: hdl/ycc2rgb_pkg.sv
// ----------------------------------------------------------------------------
// ycc2rgb_pkg
// Shared types, register codes and Q2.16 color matrix coefficients for the
// packed 10-bit YCbCr 4:2:2 to 8-bit RGBA/BGRA/UYVY converter.
// ----------------------------------------------------------------------------
package ycc2rgb_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 72;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MATRIX  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_FORMAT = 1'd1;

  localparam logic MAT_BT709  = 1'b0;
  localparam logic MAT_BT2020 = 1'b1;

  localparam logic [1:0] FMT_RGBA = 2'd0;
  localparam logic [1:0] FMT_BGRA = 2'd1;
  localparam logic [1:0] FMT_UYVY = 2'd2;
  localparam logic [1:0] FMT_RSVD = 2'd3;

  localparam logic [1:0] COUNT_ONE = 2'd1;
  localparam logic [1:0] COUNT_TWO = 2'd2;

  localparam logic [7:0] ALPHA    = 8'hFF;
  localparam logic [7:0] Y_OFFSET = 8'd16;
  localparam logic [7:0] C_OFFSET = 8'd128;

  // coefficients times 65536, rounded
  localparam logic [17:0] K_Y      = 18'd76309;
  localparam logic [17:0] K709_RV  = 18'd117489;
  localparam logic [17:0] K709_GU  = 18'd13975;
  localparam logic [17:0] K709_GV  = 18'd34925;
  localparam logic [17:0] K709_BU  = 18'd138438;
  localparam logic [17:0] K2020_RV = 18'd110014;
  localparam logic [17:0] K2020_GU = 18'd12277;
  localparam logic [17:0] K2020_GV = 18'd42626;
  localparam logic [17:0] K2020_BU = 18'd140363;

  typedef struct packed {
    logic [7:0] cb;
    logic [7:0] y0;
    logic [7:0] cr;
    logic [7:0] y1;
  } ycc_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } lane_ctrl_t;

endpackage

FILE: hdl/packed_ycbcr422_10bit_to_rgba8_unit.sv
// ----------------------------------------------------------------------------
// packed_ycbcr422_10bit_to_rgba8_unit
// Converts one packed 10-bit Cb,Y0,Cr,Y1 pgroup per transfer into two RGBA
// or BGRA words (BT.709 or BT.2020, limited range) or one 8-bit UYVY word.
//
//   channel   signals                       content
//   s_*       tvalid tready tdata[39:0]     pgroup bytes 0..4
//   m_*       tvalid tready tdata[71:0]     first_word, second_word, word_count
//   cfg_*     we index data[1:0]            0 color_matrix, 1 output_format
//
// one transfer per cycle sustained while m_tready is high; registered stages: products, sums, output
// the two pixel lanes run in parallel, each with its own five multipliers
// rst clears the stage valid bits and both registers
// a stall on m_tready holds the output; earlier stages keep filling until full
// ----------------------------------------------------------------------------
module packed_ycbcr422_10bit_to_rgba8_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24], byte4 [39:32]
  input  logic [ycc2rgb_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // first_word [31:0], second_word [63:32], word_count [65:64], zero [71:66]
  output logic [ycc2rgb_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                                 cfg_we,
  input  logic [ycc2rgb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ycc2rgb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ycc2rgb_pkg::*;

  logic       color_matrix;
  logic [1:0] output_format;
  logic       v1, v2;
  logic       en1, en2, en3;
  ycc_t       comp_in, comp1, comp2;
  lane_ctrl_t ctrl;
  rgb_t       pix0, pix1;
  logic [31:0] first_word, second_word;
  logic [1:0]  word_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_matrix  <= MAT_BT709;
      output_format <= FMT_RGBA;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_MATRIX:  color_matrix  <= cfg_data[0];
        CFG_OUTPUT_FORMAT: output_format <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack top 8 bits of each 10-bit component
  always_comb begin
    comp_in.cb = s_tdata[7:0];
    comp_in.y0 = {s_tdata[13:8], s_tdata[23:22]};
    comp_in.cr = {s_tdata[19:16], s_tdata[31:28]};
    comp_in.y1 = {s_tdata[25:24], s_tdata[39:34]};
  end

  assign en3      = !m_tvalid || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign ctrl.mul_en = en1;
  assign ctrl.sum_en = en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) comp1 <= comp_in;
    if (en2) comp2 <= comp1;
  end

  ycc2rgb_lane u_lane0 (
    .clk    (clk),
    .ctrl   (ctrl),
    .matrix (color_matrix),
    .y      (comp_in.y0),
    .cb     (comp_in.cb),
    .cr     (comp_in.cr),
    .pix    (pix0)
  );

  ycc2rgb_lane u_lane1 (
    .clk    (clk),
    .ctrl   (ctrl),
    .matrix (color_matrix),
    .y      (comp_in.y1),
    .cb     (comp_in.cb),
    .cr     (comp_in.cr),
    .pix    (pix1)
  );

  ycc2rgb_merge u_merge (
    .clk         (clk),
    .load        (en3 && v2),
    .fmt         (output_format),
    .comp        (comp2),
    .pix0        (pix0),
    .pix1        (pix1),
    .first_word  (first_word),
    .second_word (second_word),
    .word_count  (word_count)
  );

  assign m_tdata = {6'd0, word_count, second_word, first_word};

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted transfer did not enter the product stage");

  a_sum_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !en3 |=> v2)
    else $error("sum stage dropped an item while blocked");

  a_count_fmt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (output_format[1] && m_tdata[65:64] == COUNT_ONE && m_tdata[63:32] == 32'd0)
              || (!output_format[1] && m_tdata[65:64] == COUNT_TWO))
    else $error("word count does not match output format");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !output_format[1] |-> m_tdata[31:24] == ALPHA && m_tdata[63:56] == ALPHA)
    else $error("alpha byte not opaque");

endmodule

FILE: hdl/ycc2rgb_lane.sv
// ----------------------------------------------------------------------------
// ycc2rgb_lane
// One pixel of YCbCr to RGB: a registered product stage, then a registered
// sum, round and clamp stage.
// ----------------------------------------------------------------------------
module ycc2rgb_lane (
  input  logic               clk,
  input  ycc2rgb_pkg::lane_ctrl_t ctrl,
  input  logic               matrix,
  input  logic [7:0]         y,
  input  logic [7:0]         cb,
  input  logic [7:0]         cr,
  output ycc2rgb_pkg::rgb_t  pix
);
  import ycc2rgb_pkg::*;

  logic signed [8:0]  yy, u, v;
  logic [17:0]        k_rv, k_gu, k_gv, k_bu;
  logic signed [27:0] ys, prv, pgu, pgv, pbu;
  logic signed [27:0] sum_r, sum_g, sum_b;

  function automatic logic [7:0] to_byte(input logic signed [27:0] s);
    logic [27:0] t;
    begin
      t = {1'b0, s[26:0]} + 28'd32768;
      if (s[27]) to_byte = 8'd0;
      else if (t[27:16] > 12'd255) to_byte = 8'd255;
      else to_byte = t[23:16];
    end
  endfunction

  always_comb begin
    yy = $signed({1'b0, y}) - $signed({1'b0, Y_OFFSET});
    u  = $signed({1'b0, cb}) - $signed({1'b0, C_OFFSET});
    v  = $signed({1'b0, cr}) - $signed({1'b0, C_OFFSET});
    if (matrix == MAT_BT2020) begin
      k_rv = K2020_RV;
      k_gu = K2020_GU;
      k_gv = K2020_GV;
      k_bu = K2020_BU;
    end else begin
      k_rv = K709_RV;
      k_gu = K709_GU;
      k_gv = K709_GV;
      k_bu = K709_BU;
    end
  end

  // operands sign-extended to the product width
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      ys  <= 28'($signed({1'b0, K_Y})) * 28'(yy);
      prv <= 28'($signed({1'b0, k_rv})) * 28'(v);
      pgu <= 28'($signed({1'b0, k_gu})) * 28'(u);
      pgv <= 28'($signed({1'b0, k_gv})) * 28'(v);
      pbu <= 28'($signed({1'b0, k_bu})) * 28'(u);
    end
  end

  always_comb begin
    sum_r = ys + prv;
    sum_g = ys - pgu - pgv;
    sum_b = ys + pbu;
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      pix.r <= to_byte(sum_r);
      pix.g <= to_byte(sum_g);
      pix.b <= to_byte(sum_b);
    end
  end

endmodule

FILE: hdl/ycc2rgb_merge.sv
// ----------------------------------------------------------------------------
// ycc2rgb_merge
// Output register: packs the two lane pixels as RGBA or BGRA words, or the
// raw components as one UYVY word (also for the reserved format code).
// ----------------------------------------------------------------------------
module ycc2rgb_merge (
  input  logic              clk,
  input  logic              load,
  input  logic [1:0]        fmt,
  input  ycc2rgb_pkg::ycc_t comp,
  input  ycc2rgb_pkg::rgb_t pix0,
  input  ycc2rgb_pkg::rgb_t pix1,
  output logic [31:0]       first_word,
  output logic [31:0]       second_word,
  output logic [1:0]        word_count
);
  import ycc2rgb_pkg::*;

  logic [31:0] first_next, second_next;
  logic [1:0]  count_next;

  always_comb begin
    case (fmt)
      FMT_RGBA: begin
        first_next  = {ALPHA, pix0.b, pix0.g, pix0.r};
        second_next = {ALPHA, pix1.b, pix1.g, pix1.r};
        count_next  = COUNT_TWO;
      end
      FMT_BGRA: begin
        first_next  = {ALPHA, pix0.r, pix0.g, pix0.b};
        second_next = {ALPHA, pix1.r, pix1.g, pix1.b};
        count_next  = COUNT_TWO;
      end
      default: begin
        first_next  = {comp.y1, comp.cr, comp.y0, comp.cb};
        second_next = 32'd0;
        count_next  = COUNT_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_word  <= first_next;
      second_word <= second_next;
      word_count  <= count_next;
    end
  end

endmodule
